### rtl/xmca_pkg.sv
// Shared types, opcodes and helpers for the MMIO completion ALU.
package xmca_pkg;

  typedef enum logic [3:0] {
    OP_MOV   = 4'd0,
    OP_MOVZX = 4'd1,
    OP_MOVSX = 4'd2,
    OP_MOVS  = 4'd3,
    OP_STOS  = 4'd4,
    OP_LODS  = 4'd5,
    OP_AND   = 4'd6,
    OP_ADD   = 4'd7,
    OP_OR    = 4'd8,
    OP_XOR   = 4'd9,
    OP_CMP   = 4'd10,
    OP_SUB   = 4'd11,
    OP_TEST  = 4'd12,
    OP_BT    = 4'd13,
    OP_XCHG  = 4'd14,
    OP_NONE  = 4'd15
  } op_t;

  localparam logic [1:0] SK_REG = 2'd0;
  localparam logic [1:0] SK_IMM = 2'd1;
  localparam logic [1:0] SK_MEM = 2'd2;
  localparam logic [1:0] SK_BAD = 2'd3;

  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WORD  = 2'd1;
  localparam logic [1:0] SZ_DWORD = 2'd2;
  localparam logic [1:0] SZ_BAD   = 2'd3;

  localparam logic [2:0] R_EAX = 3'd0;
  localparam logic [2:0] R_ECX = 3'd1;
  localparam logic [2:0] R_ESI = 3'd6;
  localparam logic [2:0] R_EDI = 3'd7;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] mem_data;
    logic [1:0]  src_kind;
    logic [1:0]  op_size;
    logic [1:0]  dst_size;
    logic [3:0]  reg_index;
    logic        dst_is_reg;
    logic [31:0] immediate_value;
    logic        dir_down;
    logic        rep_prefix;
    logic [31:0] rep_count;
    logic [3:0]  elem_size;
  } req_t;

  typedef struct packed {
    logic        reg_written;
    logic [2:0]  written_index;
    logic [31:0] written_value;
    logic        carry_flag;
    logic        parity_flag;
    logic        adjust_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
    logic        bad_operand;
    logic        last;
  } rsp_t;

  // flags packed as {OF,SF,ZF,AF,PF,CF}
  typedef logic [5:0] flags_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: size_mask = 32'h0000_00FF;
      SZ_WORD: size_mask = 32'h0000_FFFF;
      default: size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] size_sign(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: size_sign = 32'h0000_0080;
      SZ_WORD: size_sign = 32'h0000_8000;
      default: size_sign = 32'h8000_0000;
    endcase
  endfunction

  function automatic flags_t zsp(input logic [1:0] sz, input logic [31:0] r);
    flags_t f;
    f = '0;
    f[3] = ((r & size_mask(sz)) == 32'd0);
    f[4] = ((r & size_sign(sz)) != 32'd0);
    f[1] = ~(^r[7:0]);
    zsp = f;
  endfunction

endpackage

### rtl/xmca_if.sv
// Valid/ready channel interfaces for requests and responses.
interface xmca_req_if (input logic clk);
  logic            valid;
  logic            ready;
  xmca_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface xmca_rsp_if (input logic clk);
  logic            valid;
  logic            ready;
  xmca_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/xmca_gpr_ram.sv
// Eight-entry register file memory, one write and one registered read port.
module xmca_gpr_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [2:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [2:0]  raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [8];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/xmca_alu.sv
// Per-step datapath: operand select, ALU, merge and string pointer math.
module xmca_alu (
  input  xmca_pkg::req_t     req,
  input  logic [1:0]         step,
  input  logic [1:0]         rstep,
  input  logic [31:0]        rd,
  input  xmca_pkg::flags_t   flags,
  input  logic [31:0]        stride,
  output logic [2:0]         raddr,
  output logic               wr,
  output logic [2:0]         widx,
  output logic [31:0]        wval,
  output logic               upd_flags,
  output xmca_pkg::flags_t   flags_nxt,
  output logic               bad,
  output logic               fin
);
  logic [3:0]  t;
  logic [1:0]  msz;
  logic [2:0]  pidx;
  logic [31:0] v, srcv, d, r, m, sb, a, b, ptr;
  logic        is_bt, use_reg, use_size, alu_wr, mov_bad;
  xmca_pkg::flags_t f;
  logic [2:0]  seq [3];
  logic [1:0]  nseq;

  always_comb begin
    t = req.req_type;
    d = req.mem_data;
    is_bt = (t == xmca_pkg::OP_BT);
    use_reg = (req.src_kind == xmca_pkg::SK_REG) ||
              (req.src_kind == xmca_pkg::SK_MEM && !is_bt);
    use_size = !is_bt || req.src_kind == xmca_pkg::SK_REG;
    // physical register touched by a sized access
    pidx = (req.op_size == xmca_pkg::SZ_BYTE) ? {1'b0, req.reg_index[1:0]}
                                              : req.reg_index[2:0];
    // string write sequence
    seq[0] = xmca_pkg::R_EAX; seq[1] = xmca_pkg::R_EAX; seq[2] = xmca_pkg::R_EAX;
    nseq = 2'd0;
    case (t)
      xmca_pkg::OP_MOVS: begin
        if (req.rep_prefix) begin
          seq[0] = xmca_pkg::R_ECX; seq[1] = xmca_pkg::R_ESI;
          seq[2] = xmca_pkg::R_EDI; nseq = 2'd3;
        end else begin
          seq[0] = xmca_pkg::R_ESI; seq[1] = xmca_pkg::R_EDI; nseq = 2'd2;
        end
      end
      xmca_pkg::OP_STOS: begin
        seq[0] = xmca_pkg::R_EDI; seq[1] = xmca_pkg::R_ECX;
        nseq = req.rep_prefix ? 2'd2 : 2'd1;
      end
      xmca_pkg::OP_LODS: begin
        seq[0] = xmca_pkg::R_EAX; seq[1] = xmca_pkg::R_ESI; seq[2] = xmca_pkg::R_ECX;
        nseq = req.rep_prefix ? 2'd3 : 2'd2;
      end
      default: nseq = 2'd0;
    endcase

    raddr = pidx;
    if (t == xmca_pkg::OP_MOVS || t == xmca_pkg::OP_STOS || t == xmca_pkg::OP_LODS) begin
      raddr = seq[rstep];
    end

    wr = 1'b0; widx = pidx; wval = 32'd0; upd_flags = 1'b0; flags_nxt = flags;
    bad = 1'b0; fin = 1'b1;
    v = d; msz = req.op_size; srcv = 32'd0; r = 32'd0; a = 32'd0; b = 32'd0;
    m = xmca_pkg::size_mask(req.op_size); sb = xmca_pkg::size_sign(req.op_size);
    f = '0; alu_wr = 1'b0; ptr = 32'd0; mov_bad = 1'b0;

    case (t)
      xmca_pkg::OP_MOV, xmca_pkg::OP_MOVZX, xmca_pkg::OP_MOVSX: begin
        mov_bad = req.op_size == xmca_pkg::SZ_BAD || req.reg_index[3] ||
                  (t != xmca_pkg::OP_MOV && req.dst_size == xmca_pkg::SZ_BAD);
        if (req.dst_is_reg) begin
          if (mov_bad) begin
            bad = 1'b1;
          end else begin
            if (t != xmca_pkg::OP_MOV) begin
              v = d & m;
              if (t == xmca_pkg::OP_MOVSX && (v & sb) != 32'd0) v = v | ~m;
              msz = req.dst_size;
            end
            wr = 1'b1;
          end
        end
      end
      xmca_pkg::OP_XCHG: begin
        if (req.op_size == xmca_pkg::SZ_BAD || req.reg_index[3]) bad = 1'b1;
        else wr = 1'b1;
      end
      xmca_pkg::OP_MOVS, xmca_pkg::OP_STOS, xmca_pkg::OP_LODS: begin
        if (t == xmca_pkg::OP_LODS && req.op_size == xmca_pkg::SZ_BAD) begin
          bad = 1'b1;
        end else begin
          wr = 1'b1;
          fin = ({1'b0, step} + 3'd1 >= {1'b0, nseq});
          widx = seq[step];
          ptr = req.dir_down ? rd - stride : rd + stride;
          if (seq[step] == xmca_pkg::R_ECX) ptr = rd - req.rep_count;
        end
      end
      xmca_pkg::OP_NONE: bad = 1'b0;
      default: begin
        if (req.src_kind == xmca_pkg::SK_BAD ||
            (use_size && req.op_size == xmca_pkg::SZ_BAD) ||
            (use_reg && req.reg_index[3])) begin
          bad = 1'b1;
        end else begin
          // sized register read
          if (req.op_size == xmca_pkg::SZ_BYTE && req.reg_index[2])
            srcv = {24'd0, rd[15:8]};
          else
            srcv = rd & m;
          if (req.src_kind == xmca_pkg::SK_IMM) srcv = req.immediate_value;
          else if (!use_reg) srcv = 32'd0;
          upd_flags = 1'b1;
          if (is_bt) begin
            flags_nxt[0] = d[srcv[4:0]];
          end else begin
            if (t == xmca_pkg::OP_AND || t == xmca_pkg::OP_OR ||
                t == xmca_pkg::OP_XOR || t == xmca_pkg::OP_TEST) begin
              r = (t == xmca_pkg::OP_OR) ? (d | srcv) :
                  (t == xmca_pkg::OP_XOR) ? (d ^ srcv) : (d & srcv);
              f = xmca_pkg::zsp(req.op_size, r);
              f[2] = flags[2];
            end else if (t == xmca_pkg::OP_ADD) begin
              r = d + srcv;
              f = xmca_pkg::zsp(req.op_size, r);
              f[0] = (r & m) < (d & m);
              f[5] = ((srcv ^ r) & (d ^ r) & sb) != 32'd0;
              f[2] = r[4] ^ srcv[4] ^ d[4];
            end else begin
              a = (req.src_kind == xmca_pkg::SK_MEM) ? srcv : d;
              b = (req.src_kind == xmca_pkg::SK_MEM) ? d : srcv;
              r = a - b;
              f = xmca_pkg::zsp(req.op_size, r);
              f[0] = (b & m) > (a & m);
              f[5] = ((a ^ b) & (a ^ r) & sb) != 32'd0;
              f[2] = r[4] ^ srcv[4] ^ d[4];
            end
            flags_nxt = f;
            alu_wr = req.src_kind == xmca_pkg::SK_MEM &&
                     t != xmca_pkg::OP_CMP && t != xmca_pkg::OP_TEST;
            wr = alu_wr;
            v = r;
          end
        end
      end
    endcase

    // merge into the physical register
    if (!(t == xmca_pkg::OP_MOVS || t == xmca_pkg::OP_STOS)) begin
      if (t == xmca_pkg::OP_LODS && step == 2'd0) begin
        msz = req.op_size; widx = xmca_pkg::R_EAX;
      end
      if (t != xmca_pkg::OP_LODS || step == 2'd0) begin
        if (msz == xmca_pkg::SZ_BYTE && req.reg_index[2] && t != xmca_pkg::OP_LODS) begin
          wval = {rd[31:16], v[7:0], rd[7:0]};
        end else if (msz == xmca_pkg::SZ_BYTE) begin
          wval = {rd[31:8], v[7:0]};
          if (t != xmca_pkg::OP_LODS) widx = {1'b0, req.reg_index[1:0]};
        end else if (msz == xmca_pkg::SZ_WORD) begin
          wval = {rd[31:16], v[15:0]};
          if (t != xmca_pkg::OP_LODS) widx = req.reg_index[2:0];
        end else begin
          wval = v;
          if (t != xmca_pkg::OP_LODS) widx = req.reg_index[2:0];
        end
        if (msz == xmca_pkg::SZ_BYTE && req.reg_index[2] && t != xmca_pkg::OP_LODS)
          widx = {1'b0, req.reg_index[1:0]};
      end else begin
        wval = ptr;
      end
    end else begin
      wval = ptr;
    end
  end
endmodule

### rtl/x86_mmio_completion_alu.sv
// Top level: MMIO completion ALU with register file memory and step sequencer.
//
//   channel | dir | fields
//   in_     | in  | req_t (instruction, operands, string info)
//   out_    | out | rsp_t (register write, flags, status, last)
//
// Each item passes through a read state and then an exec state that issues one result beat
// per step, up to three beats for a three-register string op; the register file
// memory port (one read, registered) sets the pace. Reset clears all registers
// through valid bits and clears the flags. A stalled out_ holds the beat in the output
// register; a new item is taken as soon as the previous one issues its last beat.
module x86_mmio_completion_alu (
  input  logic           clk,
  input  logic           rst_n,
  xmca_req_if.sink       in_ch,
  xmca_rsp_if.source     out_ch
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } st_t;

  st_t              st_r, st_nxt;
  xmca_pkg::req_t   req_r;
  logic [1:0]       step_r;
  xmca_pkg::flags_t flags_r;
  logic [7:0]       vld_r;
  logic [31:0]      stride_r;
  logic             ovld_r;
  xmca_pkg::rsp_t   odat_r;

  logic [2:0]  raddr, widx, rsel;
  logic [31:0] rdata, rd, wval;
  logic        wr, upd, bad, fin, fire;
  xmca_pkg::flags_t fnx;
  logic [1:0]  rd_step;
  logic        out_free;

  // read address for the coming exec cycle: msz-based index for merge
  logic [2:0] raddr_merge;

  assign out_free = !ovld_r || out_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE) || (st_r == S_EXEC && out_free && fin);

  xmca_alu u_alu (
    .req(req_r), .step(step_r), .rstep(rd_step), .rd(rd), .flags(flags_r),
    .stride(stride_r), .raddr(raddr), .wr(wr), .widx(widx), .wval(wval),
    .upd_flags(upd), .flags_nxt(fnx), .bad(bad), .fin(fin)
  );

  // the step being read: next step while executing, else the current step
  assign rd_step = (st_r == S_EXEC && out_free && !fin) ? step_r + 2'd1 : step_r;

  always_comb begin
    raddr_merge = raddr;
    if (req_r.req_type == xmca_pkg::OP_MOVZX || req_r.req_type == xmca_pkg::OP_MOVSX) begin
      raddr_merge = (req_r.dst_size == xmca_pkg::SZ_BYTE) ? {1'b0, req_r.reg_index[1:0]}
                                                          : req_r.reg_index[2:0];
    end
  end

  assign rsel = raddr_merge;
  assign fire = st_r == S_EXEC && out_free;

  xmca_gpr_ram u_ram (
    .clk(clk), .we(fire && wr), .waddr(widx), .wdata(wval), .raddr(rsel), .rdata(rdata)
  );

  // forward a same-entry write from the previous exec beat
  logic        fwd_r;
  logic [31:0] fwd_val_r;
  logic [2:0]  rsel_r;
  assign rd = fwd_r ? fwd_val_r : (vld_r[rsel_r] ? rdata : 32'd0);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_ch.valid) st_nxt = S_READ;
      S_READ: st_nxt = S_EXEC;
      S_EXEC: if (fire && fin) st_nxt = in_ch.valid ? S_READ : S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      flags_r <= '0;
      vld_r <= '0;
      ovld_r <= 1'b0;
      step_r <= 2'd0;
      fwd_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fwd_r <= fire && wr && widx == rsel;
      ovld_r <= fire || (ovld_r && !out_ch.ready);
      if (fire) begin
        if (wr) vld_r[widx] <= 1'b1;
        if (upd) flags_r <= fnx;
        step_r <= fin ? 2'd0 : step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsel_r <= rsel;
    fwd_val_r <= wval;
    if (in_ch.valid && in_ch.ready) begin
      req_r <= in_ch.data;
      stride_r <= in_ch.data.rep_count * {28'd0, in_ch.data.elem_size};
    end
    if (fire) begin
      odat_r.reg_written <= wr;
      odat_r.written_index <= wr ? widx : 3'd0;
      odat_r.written_value <= wr ? wval : 32'd0;
      odat_r.carry_flag <= upd ? fnx[0] : flags_r[0];
      odat_r.parity_flag <= upd ? fnx[1] : flags_r[1];
      odat_r.adjust_flag <= upd ? fnx[2] : flags_r[2];
      odat_r.zero_flag <= upd ? fnx[3] : flags_r[3];
      odat_r.sign_flag <= upd ? fnx[4] : flags_r[4];
      odat_r.overflow_flag <= upd ? fnx[5] : flags_r[5];
      odat_r.bad_operand <= bad;
      odat_r.last <= fin;
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.data = odat_r;
endmodule

### tb/tb_top.sv
// Testbench top: random and directed instructions, scoreboard and handshake drivers.
`timescale 1ns / 1ps
module tb_top;
  import xmca_pkg::*;

  class gpr_scoreboard;
    logic [31:0] gpr [8];
    flags_t      fl;
    rsp_t        pending [$];
    int          errors;

    function new();
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      fl = '0;
      errors = 0;
    endfunction

    function logic [31:0] rd(logic [1:0] sz, logic [3:0] idx);
      logic [2:0] i;
      i = idx[2:0];
      if (sz == SZ_BYTE)
        return i < 3'd4 ? {24'd0, gpr[i][7:0]} : {24'd0, gpr[i - 3'd4][15:8]};
      return gpr[i] & size_mask(sz);
    endfunction

    function logic [2:0] merge(logic [1:0] sz, logic [3:0] idx, logic [31:0] v);
      logic [2:0] i;
      i = idx[2:0];
      if (sz == SZ_BYTE) begin
        if (i < 3'd4) begin
          gpr[i][7:0] = v[7:0];
          return i;
        end
        gpr[i - 3'd4][15:8] = v[7:0];
        return i - 3'd4;
      end
      if (sz == SZ_WORD) gpr[i][15:0] = v[15:0];
      else gpr[i] = v;
      return i;
    endfunction

    function flags_t zsp_of(logic [1:0] sz, logic [31:0] r);
      flags_t f;
      f = '0;
      f[3] = (r & size_mask(sz)) == 32'd0;
      f[4] = (r & size_sign(sz)) != 32'd0;
      f[1] = ~(^r[7:0]);
      return f;
    endfunction

    function void note_request(req_t q);
      logic [2:0]  wi [$];
      logic [31:0] wv [$];
      logic [31:0] step, v, r, m, sb, a, b;
      logic        bad, is_bt, use_reg, use_size;
      flags_t      f;
      rsp_t        e;
      bad = 1'b0;
      step = q.rep_count * {28'd0, q.elem_size};
      if (q.req_type <= OP_MOVSX) begin
        if (q.dst_is_reg) begin
          if (q.op_size == SZ_BAD || q.reg_index > 4'd7 ||
              (q.req_type != OP_MOV && q.dst_size == SZ_BAD)) bad = 1'b1;
          else begin
            v = q.mem_data;
            if (q.req_type != OP_MOV) begin
              v &= size_mask(q.op_size);
              if (q.req_type == OP_MOVSX && (v & size_sign(q.op_size)) != 32'd0)
                v |= ~size_mask(q.op_size);
            end
            wi.push_back(merge(q.req_type == OP_MOV ? q.op_size : q.dst_size,
                               q.reg_index, v));
            wv.push_back(gpr[wi[$]]);
          end
        end
      end else if (q.req_type <= OP_LODS) begin
        if (q.req_type == OP_LODS && q.op_size == SZ_BAD) bad = 1'b1;
        else begin
          if (q.req_type == OP_LODS) begin
            wi.push_back(merge(q.op_size, 4'd0, q.mem_data));
            wv.push_back(gpr[R_EAX]);
          end
          if (q.req_type == OP_MOVS && q.rep_prefix) begin
            gpr[R_ECX] -= q.rep_count;
            wi.push_back(R_ECX); wv.push_back(gpr[R_ECX]);
          end
          if (q.req_type != OP_STOS) begin
            gpr[R_ESI] = q.dir_down ? gpr[R_ESI] - step : gpr[R_ESI] + step;
            wi.push_back(R_ESI); wv.push_back(gpr[R_ESI]);
          end
          if (q.req_type != OP_LODS) begin
            gpr[R_EDI] = q.dir_down ? gpr[R_EDI] - step : gpr[R_EDI] + step;
            wi.push_back(R_EDI); wv.push_back(gpr[R_EDI]);
          end
          if (q.req_type != OP_MOVS && q.rep_prefix) begin
            gpr[R_ECX] -= q.rep_count;
            wi.push_back(R_ECX); wv.push_back(gpr[R_ECX]);
          end
        end
      end else if (q.req_type <= OP_BT) begin
        is_bt = q.req_type == OP_BT;
        use_reg = q.src_kind == SK_REG || (q.src_kind == SK_MEM && !is_bt);
        use_size = !is_bt || q.src_kind == SK_REG;
        if (q.src_kind == SK_BAD || (use_size && q.op_size == SZ_BAD) ||
            (use_reg && q.reg_index > 4'd7)) bad = 1'b1;
        else begin
          v = q.src_kind == SK_IMM ? q.immediate_value :
              (use_reg ? rd(q.op_size, q.reg_index) : 32'd0);
          if (is_bt) fl[0] = q.mem_data[v[4:0]];
          else begin
            m = size_mask(q.op_size);
            sb = size_sign(q.op_size);
            if (q.req_type inside {OP_AND, OP_OR, OP_XOR, OP_TEST}) begin
              r = q.req_type == OP_OR ? (q.mem_data | v) :
                  (q.req_type == OP_XOR ? (q.mem_data ^ v) : (q.mem_data & v));
              f = zsp_of(q.op_size, r);
              f[2] = fl[2];
            end else if (q.req_type == OP_ADD) begin
              r = q.mem_data + v;
              f = zsp_of(q.op_size, r);
              f[0] = (r & m) < (q.mem_data & m);
              f[5] = ((v ^ r) & (q.mem_data ^ r) & sb) != 32'd0;
              f[2] = r[4] ^ v[4] ^ q.mem_data[4];
            end else begin
              a = q.src_kind == SK_MEM ? v : q.mem_data;
              b = q.src_kind == SK_MEM ? q.mem_data : v;
              r = a - b;
              f = zsp_of(q.op_size, r);
              f[0] = (b & m) > (a & m);
              f[5] = ((a ^ b) & (a ^ r) & sb) != 32'd0;
              f[2] = r[4] ^ v[4] ^ q.mem_data[4];
            end
            fl = f;
            if (q.src_kind == SK_MEM && q.req_type != OP_CMP && q.req_type != OP_TEST) begin
              wi.push_back(merge(q.op_size, q.reg_index, r));
              wv.push_back(gpr[wi[$]]);
            end
          end
        end
      end else if (q.req_type == OP_XCHG) begin
        if (q.op_size == SZ_BAD || q.reg_index > 4'd7) bad = 1'b1;
        else begin
          wi.push_back(merge(q.op_size, q.reg_index, q.mem_data));
          wv.push_back(gpr[wi[$]]);
        end
      end
      e = '0;
      {e.overflow_flag, e.sign_flag, e.zero_flag, e.adjust_flag, e.parity_flag,
       e.carry_flag} = fl;
      if (wi.size() == 0) begin
        e.bad_operand = bad;
        e.last = 1'b1;
        pending.push_back(e);
      end
      for (int k = 0; k < wi.size(); k++) begin
        e.reg_written = 1'b1;
        e.written_index = wi[k];
        e.written_value = wv[k];
        e.last = (k == wi.size() - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_beat(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected beat %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.reg_written !== e.reg_written) begin
        $error("reg_written exp %0d got %0d", e.reg_written, got.reg_written); errors++;
      end
      if (got.written_index !== e.written_index) begin
        $error("written_index exp %0d got %0d", e.written_index, got.written_index);
        errors++;
      end
      if (got.written_value !== e.written_value) begin
        $error("written_value exp %h got %h", e.written_value, got.written_value);
        errors++;
      end
      if (got.carry_flag !== e.carry_flag) begin
        $error("carry_flag exp %0d got %0d", e.carry_flag, got.carry_flag); errors++;
      end
      if (got.parity_flag !== e.parity_flag) begin
        $error("parity_flag exp %0d got %0d", e.parity_flag, got.parity_flag); errors++;
      end
      if (got.adjust_flag !== e.adjust_flag) begin
        $error("adjust_flag exp %0d got %0d", e.adjust_flag, got.adjust_flag); errors++;
      end
      if (got.zero_flag !== e.zero_flag) begin
        $error("zero_flag exp %0d got %0d", e.zero_flag, got.zero_flag); errors++;
      end
      if (got.sign_flag !== e.sign_flag) begin
        $error("sign_flag exp %0d got %0d", e.sign_flag, got.sign_flag); errors++;
      end
      if (got.overflow_flag !== e.overflow_flag) begin
        $error("overflow_flag exp %0d got %0d", e.overflow_flag, got.overflow_flag);
        errors++;
      end
      if (got.bad_operand !== e.bad_operand) begin
        $error("bad_operand exp %0d got %0d", e.bad_operand, got.bad_operand); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  xmca_req_if in_ch (clk);
  xmca_rsp_if out_ch (clk);
  gpr_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_off = 0;

  x86_mmio_completion_alu dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000 | $urandom_range(0, 3);
      3: return $urandom_range(0, 255);
      4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.req_type = 4'($urandom_range(0, 15));
    q.mem_data = pick32();
    q.src_kind = ($urandom_range(0, 9) == 0) ? SK_BAD : 2'($urandom_range(0, 2));
    q.op_size = ($urandom_range(0, 11) == 0) ? SZ_BAD : 2'($urandom_range(0, 2));
    q.dst_size = ($urandom_range(0, 11) == 0) ? SZ_BAD : 2'($urandom_range(0, 2));
    q.reg_index = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                              : 4'($urandom_range(0, 7));
    q.dst_is_reg = $urandom_range(0, 4) != 0;
    q.immediate_value = pick32();
    q.dir_down = 1'($urandom);
    q.rep_prefix = 1'($urandom);
    q.rep_count = ($urandom_range(0, 3) == 0) ? pick32() : $urandom_range(0, 40);
    q.elem_size = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 8));
    return q;
  endfunction

  task automatic send(req_t q);
    in_ch.valid <= 1;
    in_ch.data <= q;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(q);
    @(negedge clk);
  endtask

  task automatic send_gap();
    in_ch.valid <= 0;
    in_ch.data <= rand_req();
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_beat(out_ch.data);
  end

  always @(negedge clk) begin
    if (hold_off || !rst_n) out_ch.ready <= 0;
    else if (cycles % 200 < 60) out_ch.ready <= 1;
    else out_ch.ready <= $urandom_range(0, 3) != 0;
  end

  initial begin
    wait (cycles == 400);
    @(negedge clk);
    hold_off = 1;
    repeat (150) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    wait (cycles == 200000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    req_t q;
    int   burst;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    for (int t = 0; t < 16; t++) begin
      q = rand_req();
      q.req_type = 4'(t);
      q.src_kind = (t[1:0] == 2'd3) ? SK_MEM : t[1:0];
      q.op_size = 2'(t % 3);
      q.dst_size = SZ_WORD;
      q.reg_index = {1'b0, t[2:0]};
      q.dst_is_reg = 1;
      q.rep_prefix = 1;
      q.elem_size = (t % 2 != 0) ? 4'd8 : 4'd1;
      send(q);
    end
    q.req_type = OP_ADD; q.src_kind = SK_IMM; q.op_size = SZ_DWORD;
    q.mem_data = 32'h7FFF_FFFF; q.immediate_value = 32'd1; send(q);
    q.req_type = OP_SUB; q.src_kind = SK_MEM; q.reg_index = 4'd15; send(q);
    q.req_type = OP_CMP; q.src_kind = SK_BAD; q.reg_index = 4'd0; send(q);
    q.req_type = OP_MOVSX; q.dst_size = SZ_BAD; send(q);
    q.req_type = OP_LODS; q.op_size = SZ_BAD; send(q);
    q.req_type = OP_MOV; q.op_size = SZ_BYTE; q.reg_index = 4'd7;
    q.mem_data = 32'hFFFF_FFFF; send(q);
    q.req_type = OP_BT; q.src_kind = SK_IMM; q.immediate_value = 32'hFFFF_FFFF; send(q);
    q.req_type = OP_MOVS; q.rep_count = 32'hFFFF_FFFF; q.elem_size = 4'd15;
    q.dir_down = 1; send(q);
    for (int n = 0; n < 245; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++, n++) send(rand_req());
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
